// ===== rtl/core/sdiv_pkg.sv =====
`timescale 1ns / 1ps

package sdiv_pkg;

   // Per-item control that rides down the pipeline with the data.
   typedef struct packed {
      logic valid;         // stage holds a live item
      logic quotient_neg;  // operand signs differ
      logic remainder_neg; // dividend is negative
   } sdiv_ctl_type;

   localparam sdiv_ctl_type CTL_IDLE = '{valid: 1'b0, quotient_neg: 1'b0, remainder_neg: 1'b0};

endpackage

// ===== rtl/core/sdiv_channels.sv =====
`timescale 1ns / 1ps

// Operand channel: dividend and divisor.
interface sdiv_req_if #(
   parameter int DATA_WIDTH = 8
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend;
   logic signed [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// Result channel: quotient and remainder.
interface sdiv_rsp_if #(
   parameter int DATA_WIDTH = 8
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic signed [DATA_WIDTH-1:0] remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/core/sdiv_step.sv =====
`timescale 1ns / 1ps

// One registered restoring step: shift A:Q left, trial-subtract M, keep or restore.
module sdiv_step #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  sdiv_pkg::sdiv_ctl_type     ctl_i,
   input  logic [DATA_WIDTH-1:0]      acc_i,
   input  logic [DATA_WIDTH-1:0]      q_i,
   input  logic [DATA_WIDTH-1:0]      m_i,
   output sdiv_pkg::sdiv_ctl_type     ctl_o,
   output logic [DATA_WIDTH-1:0]      acc_o,
   output logic [DATA_WIDTH-1:0]      q_o,
   output logic [DATA_WIDTH-1:0]      m_o
);

   sdiv_pkg::sdiv_ctl_type  ctl_ff;
   logic [DATA_WIDTH-1:0]   acc_ff, acc_in;
   logic [DATA_WIDTH-1:0]   q_ff, q_in;
   logic [DATA_WIDTH-1:0]   m_ff;
   logic [DATA_WIDTH-1:0]   shifted;
   logic [DATA_WIDTH-1:0]   diff;

   always_comb begin
      shifted = {acc_i[DATA_WIDTH-2:0], q_i[DATA_WIDTH-1]};
      diff    = shifted - m_i;
      // negative trial result: restore, which is just the shifted value
      acc_in  = diff[DATA_WIDTH-1] ? shifted : diff;
      q_in    = {q_i[DATA_WIDTH-2:0], ~diff[DATA_WIDTH-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= sdiv_pkg::CTL_IDLE;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff <= acc_in;
         q_ff   <= q_in;
         m_ff   <= m_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign acc_o = acc_ff;
   assign q_o   = q_ff;
   assign m_o   = m_ff;

endmodule

// ===== rtl/core/signed_restoring_divider_8bit.sv =====
`timescale 1ns / 1ps

// Signed restoring divider, DATA_WIDTH-bit two's complement operands.
// req_chan carries dividend and divisor; rsp_chan returns quotient (truncated
// toward zero, wraps on most-negative / -1) and remainder (dividend's sign).
// A zero divisor is not flagged; the steps run as usual.
// From an operand transfer to its result: an input register takes operand
// magnitudes, one pipeline stage per quotient bit (one subtractor each), and
// the output register takes the result after the signs are applied.
// Throughput: one transfer per cycle in each direction while rsp_chan.ready
// is high.
// Stall: the whole pipeline holds while a result waits and rsp_chan.ready is
// low; req_chan.ready drops with it, so nothing is dropped or repeated.
// Empty slots in the pipeline keep moving whenever the output is free.
// Reset (synchronous, active high) clears all valid bits; data registers are
// not reset.
module signed_restoring_divider_8bit #(
   parameter int DATA_WIDTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   sdiv_req_if.sink  req_chan,
   sdiv_rsp_if.source rsp_chan
);

   // whole pipeline moves when the output slot is empty or being taken
   logic advance;

   // stage 0 = magnitudes; stage k = after k restoring steps
   sdiv_pkg::sdiv_ctl_type ctl_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]  acc_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]  q_pipe   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]  m_pipe   [0:DATA_WIDTH];

   // input stage
   sdiv_pkg::sdiv_ctl_type ctl0_ff, ctl0_in;
   logic [DATA_WIDTH-1:0]  q0_ff, q0_in;
   logic [DATA_WIDTH-1:0]  m0_ff, m0_in;

   // output register
   logic                   rsp_valid_ff;
   logic [DATA_WIDTH-1:0]  quotient_ff, quotient_in;
   logic [DATA_WIDTH-1:0]  remainder_ff, remainder_in;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      ctl0_in.valid         = req_chan.valid;
      ctl0_in.quotient_neg  = req_chan.dividend[DATA_WIDTH-1] ^ req_chan.divisor[DATA_WIDTH-1];
      ctl0_in.remainder_neg = req_chan.dividend[DATA_WIDTH-1];
      // most negative value negates to itself and is then read as unsigned
      q0_in = req_chan.dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-req_chan.dividend)
                                              : DATA_WIDTH'(req_chan.dividend);
      m0_in = req_chan.divisor[DATA_WIDTH-1]  ? DATA_WIDTH'(-req_chan.divisor)
                                              : DATA_WIDTH'(req_chan.divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= sdiv_pkg::CTL_IDLE;
      end else if (advance) begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q0_ff <= q0_in;
         m0_ff <= m0_in;
      end
   end

   assign ctl_pipe[0] = ctl0_ff;
   assign acc_pipe[0] = '0;
   assign q_pipe[0]   = q0_ff;
   assign m_pipe[0]   = m0_ff;

   // one stage per quotient bit, MSB first
   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
      sdiv_step #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (ctl_pipe[k]),
         .acc_i   (acc_pipe[k]),
         .q_i     (q_pipe[k]),
         .m_i     (m_pipe[k]),
         .ctl_o   (ctl_pipe[k+1]),
         .acc_o   (acc_pipe[k+1]),
         .q_o     (q_pipe[k+1]),
         .m_o     (m_pipe[k+1])
      );
   end

   // sign fix-up: negate quotient on differing signs, remainder follows dividend
   always_comb begin
      quotient_in  = ctl_pipe[DATA_WIDTH].quotient_neg  ? (~q_pipe[DATA_WIDTH] + 1'b1)
                                                        : q_pipe[DATA_WIDTH];
      remainder_in = ctl_pipe[DATA_WIDTH].remainder_neg ? (~acc_pipe[DATA_WIDTH] + 1'b1)
                                                        : acc_pipe[DATA_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_pipe[DATA_WIDTH].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff  <= quotient_in;
         remainder_ff <= remainder_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.quotient  = quotient_ff;
   assign rsp_chan.remainder = remainder_ff;

endmodule
